// File: sv/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

    // Default sizes handed to the top level parameters.
    localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
    localparam int unsigned ADDRESS_BITS_DEF      = 64;

    // Bytes held by the two pattern registers; bytes beyond these are wildcards.
    localparam int unsigned PAT_BYTES = 16;

    // Configuration port sizes.
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned APB_ADDR_W = 6;

    // Depth of the result queue in front of the output channel.
    localparam int unsigned OUT_FIFO_DEPTH = 4;

    // Width of the hit address field on the output channel.
    localparam int unsigned HIT_ADDR_W = 64;

    // Register indexes on the configuration port (byte address is 8 times the index).
    typedef enum logic [2:0] {
        REG_PAT_LO = 3'd0,
        REG_PAT_HI = 3'd1,
        REG_CARE   = 3'd2,
        REG_LEN    = 3'd3,
        REG_START  = 3'd4,
        REG_BACK   = 3'd5,
        REG_FIRST  = 3'd6
    } wbps_reg_t;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic [63:0] pattern_low_bytes;
        logic [63:0] pattern_high_bytes;
        logic [15:0] care_mask;
        logic [4:0]  pattern_length;
        logic [63:0] start_address;
        logic        scan_backward;
        logic        first_hit_only;
    } wbps_cfg_t;

    // Pattern bytes and care bits handed to every comparison cell.
    typedef struct packed {
        logic [PAT_BYTES-1:0]   care;
        logic [8*PAT_BYTES-1:0] bytes;
    } wbps_pat_t;

    // One result word as queued for the output channel.
    typedef struct packed {
        logic [HIT_ADDR_W-1:0] hit_address;
        logic                  found;
        logic                  region_done;
    } wbps_res_t;

endpackage

// File: sv/wbps_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module wbps_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output wbps_pkg::wbps_cfg_t              cfg
);

    wbps_pkg::wbps_reg_t reg_index;
    logic                wr_en;

    wbps_pkg::wbps_cfg_t cfg_reg;
    wbps_pkg::wbps_cfg_t cfg_next;

    // Registers sit on 8-byte boundaries; the low address bits are ignored.
    assign reg_index = wbps_pkg::wbps_reg_t'(paddr[5:3]);
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign cfg       = cfg_reg;

    // Write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_index)
                wbps_pkg::REG_PAT_LO: cfg_next.pattern_low_bytes  = pwdata;
                wbps_pkg::REG_PAT_HI: cfg_next.pattern_high_bytes = pwdata;
                wbps_pkg::REG_CARE:   cfg_next.care_mask          = pwdata[15:0];
                wbps_pkg::REG_LEN:    cfg_next.pattern_length     = pwdata[4:0];
                wbps_pkg::REG_START:  cfg_next.start_address      = pwdata;
                wbps_pkg::REG_BACK:   cfg_next.scan_backward      = pwdata[0];
                wbps_pkg::REG_FIRST:  cfg_next.first_hit_only     = pwdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file; reset gives a one-byte pattern with every byte cared for.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_low_bytes  <= '0;
            cfg_reg.pattern_high_bytes <= '0;
            cfg_reg.care_mask          <= 16'hFFFF;
            cfg_reg.pattern_length     <= 5'd1;
            cfg_reg.start_address      <= '0;
            cfg_reg.scan_backward      <= 1'b0;
            cfg_reg.first_hit_only     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_index)
            wbps_pkg::REG_PAT_LO: prdata = cfg_reg.pattern_low_bytes;
            wbps_pkg::REG_PAT_HI: prdata = cfg_reg.pattern_high_bytes;
            wbps_pkg::REG_CARE:   prdata = 64'(cfg_reg.care_mask);
            wbps_pkg::REG_LEN:    prdata = 64'(cfg_reg.pattern_length);
            wbps_pkg::REG_START:  prdata = cfg_reg.start_address;
            wbps_pkg::REG_BACK:   prdata = 64'(cfg_reg.scan_backward);
            wbps_pkg::REG_FIRST:  prdata = 64'(cfg_reg.first_hit_only);
            default:              prdata = '0;
        endcase
    end

endmodule

// File: sv/wbps_cell.sv
// One window cell: holds one byte, passes it on, and compares it with its pattern byte.
`timescale 1ns / 1ps

module wbps_cell
#(
    parameter int unsigned CELL_INDEX = 0,
    parameter int unsigned LEN_W      = 5
)
(
    input  logic                  clk,
    input  logic                  shift,
    input  logic [7:0]            byte_in,
    output logic [7:0]            byte_out,
    input  wbps_pkg::wbps_pat_t   pat,
    input  logic [LEN_W-1:0]      len,
    input  logic                  back,
    output logic                  match
);

    logic [7:0]       byte_reg;
    logic [LEN_W-1:0] pat_idx;
    logic [3:0]       sel;
    logic             in_use;
    logic             stored;
    logic             care_bit;
    logic [7:0]       pat_byte;

    // Byte storage; the chain moves one place on every accepted word.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Backward scans compare pattern byte i with the i-th newest byte,
    // forward scans with the i-th oldest byte of the window.
    always_comb
    begin
        in_use   = 32'(len) > CELL_INDEX;
        pat_idx  = back ? LEN_W'(CELL_INDEX) : (len - LEN_W'(1) - LEN_W'(CELL_INDEX));
        stored   = 32'(pat_idx) < wbps_pkg::PAT_BYTES;
        sel      = 4'(pat_idx);
        care_bit = stored && pat.care[sel];
        pat_byte = pat.bytes[8*sel +: 8];
        match    = !in_use || !care_bit || (pat_byte == byte_reg);
    end

endmodule

// File: sv/wbps_out_fifo.sv
// Small result queue that decouples the scanner from the output channel.
`timescale 1ns / 1ps

module wbps_out_fifo
#(
    parameter int unsigned DEPTH = wbps_pkg::OUT_FIFO_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  wbps_pkg::wbps_res_t               push_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output wbps_pkg::wbps_res_t               out_data,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    wbps_pkg::wbps_res_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The queue never takes a word while full unless one leaves in the same cycle.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> 32'(count_reg) < DEPTH)
        else $error("result queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("result queue underflow");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("result queue count did not rise on push");

endmodule

// File: sv/wildcard_byte_pattern_scanner_top.sv
// Top level of the wildcard byte pattern scanner.
`timescale 1ns / 1ps

// Scans a stream of bytes for a pattern of up to 16 bytes with per-byte wildcards.
// Input channel (s_*): one byte of the scanned region per word, tlast on the
// region's final byte. Output channel (m_*): one word per reported hit, or one
// not-found word at the region end in first-hit-only mode. m_tdata carries the
// hit address (0 for not-found), m_tuser is set for a hit, m_tlast marks a word
// that comes with the region's final byte.
// The APB port holds the pattern, care mask, length, start address and mode bits;
// the user must write it only while no region is in flight; nothing enforces it.
// Throughput is one byte per cycle while s_tready is high: the byte window is a
// chain of cells that shifts on every accepted word and compares all positions
// in parallel. The accepting edge loads the window and the compare-stage
// registers; the compare and address are worked out from them and written into
// a four-word result queue, whose fill drives m_tvalid. s_tready depends only
// on the queue fill and the word in the compare stage, and is low while the two
// together reach four, so a stalled receiver lets the input run on until the
// queue holds four words, or three with a byte still in the compare stage.
// Reset empties the queue, clears the region state and loads the register
// defaults (one-byte pattern, all bytes cared for, forward, every hit).

module wildcard_byte_pattern_scanner_top
#(
    parameter int unsigned MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF,
    parameter int unsigned ADDRESS_BITS      = wbps_pkg::ADDRESS_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // region_last
    // Output channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // [63:0] hit_address
    output logic                             m_tuser,   // [0] found
    output logic                             m_tlast,   // region_done
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [wbps_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [wbps_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int unsigned LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int unsigned AW     = ADDRESS_BITS;
    localparam int unsigned DEPTH  = wbps_pkg::OUT_FIFO_DEPTH;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    wbps_pkg::wbps_cfg_t cfg;
    wbps_pkg::wbps_pat_t pat;
    wbps_pkg::wbps_res_t res;
    wbps_pkg::wbps_res_t out_word;

    logic [LEN_W-1:0] len_eff;
    logic             s_acc;
    logic             first;

    logic [7:0]       cell_byte [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_match;

    // Region state at the input side.
    logic [LEN_W-1:0] seen_reg;
    logic [LEN_W-1:0] seen_next;
    logic [LEN_W-1:0] seen_inc;
    logic [AW-1:0]    cur_reg;
    logic [AW-1:0]    cur_next;
    logic [AW-1:0]    here;
    logic [AW-1:0]    start_a;

    // Compare stage.
    logic             s1_valid_reg;
    logic [AW-1:0]    s1_here_reg;
    logic [LEN_W-1:0] s1_seen_reg;
    logic             s1_last_reg;
    logic             hit_seen_reg;
    logic             hit_seen_next;
    logic             hit;
    logic             report_hit;
    logic             report_nf;
    logic             push;
    logic [AW-1:0]    hit_addr;

    logic [CNT_W-1:0] fifo_count;

    // Register file.
    wbps_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Effective pattern length: zero acts as one, long values clip to the window size.
    always_comb
    begin
        if (cfg.pattern_length == 5'd0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (32'(cfg.pattern_length) > MAX_PATTERN_BYTES)
        begin
            len_eff = LEN_W'(MAX_PATTERN_BYTES);
        end
        else
        begin
            len_eff = LEN_W'(cfg.pattern_length);
        end
    end

    assign pat.care  = cfg.care_mask;
    assign pat.bytes = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

    // Window cells; cell 0 holds the newest byte.
    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN_BYTES; gi++)
        begin : g_cell
            wbps_cell
            #(
                .CELL_INDEX (gi),
                .LEN_W      (LEN_W)
            )
            u_cell
            (
                .clk      (clk),
                .shift    (s_acc),
                .byte_in  ((gi == 0) ? s_tdata : cell_byte[(gi == 0) ? 0 : gi - 1]),
                .byte_out (cell_byte[gi]),
                .pat      (pat),
                .len      (len_eff),
                .back     (cfg.scan_backward),
                .match    (cell_match[gi])
            );
        end
    endgenerate

    // Input acceptance: room for the word in the compare stage and one queued result.
    assign s_tready = ((CNT_W + 1)'(fifo_count) + (CNT_W + 1)'(s1_valid_reg))
                      < (CNT_W + 1)'(DEPTH);
    assign s_acc    = s_tvalid && s_tready;

    // Address of the incoming byte and of the one after it.
    always_comb
    begin
        start_a  = cfg.start_address[AW-1:0];
        first    = seen_reg == '0;
        seen_inc = (32'(seen_reg) >= MAX_PATTERN_BYTES) ? seen_reg : seen_reg + LEN_W'(1);
        if (first)
        begin
            here     = cfg.scan_backward ? start_a - AW'(1) : start_a;
            cur_next = cfg.scan_backward ? start_a - AW'(2) : start_a + AW'(1);
        end
        else
        begin
            here     = cur_reg;
            cur_next = cfg.scan_backward ? cur_reg - AW'(1) : cur_reg + AW'(1);
        end
        seen_next = s_tlast ? '0 : seen_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s_acc;
            if (s_acc)
            begin
                seen_reg <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            cur_reg     <= cur_next;
            s1_here_reg <= here;
            s1_seen_reg <= seen_inc;
            s1_last_reg <= s_tlast;
        end
    end

    // Compare stage: window result, hit address and report decision.
    always_comb
    begin
        hit        = s1_valid_reg && (s1_seen_reg >= len_eff) && (&cell_match);
        hit_addr   = cfg.scan_backward ? s1_here_reg
                                       : s1_here_reg - AW'(len_eff - LEN_W'(1));
        report_hit = hit && !(cfg.first_hit_only && hit_seen_reg);
        report_nf  = !report_hit && s1_valid_reg && s1_last_reg
                     && cfg.first_hit_only && !hit_seen_reg;
        push       = report_hit || report_nf;

        res.hit_address = report_hit ? 64'(hit_addr) : '0;
        res.found       = report_hit;
        res.region_done = s1_last_reg;

        hit_seen_next = hit_seen_reg;
        if (s1_valid_reg)
        begin
            if (s1_last_reg)
            begin
                hit_seen_next = 1'b0;
            end
            else if (report_hit)
            begin
                hit_seen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_seen_reg <= 1'b0;
        end
        else
        begin
            hit_seen_reg <= hit_seen_next;
        end
    end

    // Result queue.
    wbps_out_fifo
    #(
        .DEPTH (DEPTH)
    )
    u_out_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_word),
        .count     (fifo_count)
    );

    assign m_tdata = out_word.hit_address;
    assign m_tuser = out_word.found;
    assign m_tlast = out_word.region_done;

    // The fill count never runs past the window size.
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(seen_reg) <= MAX_PATTERN_BYTES)
        else $error("bytes seen count beyond window size");

    // A region's final byte restarts the count.
    a_seen_restart: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tlast |=> seen_reg == '0)
        else $error("bytes seen not cleared at region end");

    // The hit flag never survives the end of a region.
    a_hit_seen_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |=> !hit_seen_reg)
        else $error("hit flag kept past region end");

    // A not-found report only appears at a region end in first-hit-only mode.
    a_nf_context: assert property (@(posedge clk) disable iff (!rst_n)
        push && !res.found |-> s1_last_reg && cfg.first_hit_only && !hit_seen_reg)
        else $error("not-found report outside a first-hit-only region end");

    // A suppressed repeat hit never reaches the queue.
    a_first_only: assert property (@(posedge clk) disable iff (!rst_n)
        push && res.found && cfg.first_hit_only |-> !hit_seen_reg)
        else $error("second hit reported in first-hit-only mode");

endmodule
